// File: design/sxd_pkg.sv
package sxd_pkg;

   localparam int ROW_W   = 64;
   localparam int COORD_W = 6;
   localparam int SPR_W   = 8;
   localparam int OFF_W   = 4;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [7:0]       x_pos;
      logic [7:0]       y_pos;
      logic [OFF_W-1:0] row_offset;
      logic [SPR_W-1:0] sprite_byte;
   } req_type;

   typedef struct packed {
      logic             collision;
      logic [ROW_W-1:0] row_bits;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic fetch;
      logic commit;
   } cmd_type;

   // remainder of an 8-bit value by a divisor of 8 to 64, quotient below 32
   function automatic logic [COORD_W-1:0] mod_small(logic [7:0] value, logic [6:0] divisor);
      logic [11:0] rem;
      logic [11:0] step;
      rem = {4'd0, value};
      for (int k = 4; k >= 0; k--) begin
         step = {5'd0, divisor} << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[COORD_W-1:0];
   endfunction

endpackage

// File: design/sxd_ram.sv
module sxd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sxd_ctrl.sv
module sxd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sxd_pkg::cmd_type cmd
);

   import sxd_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/sxd_datapath.sv
module sxd_datapath #(
   parameter int SCREEN_W = 64,
   parameter int SCREEN_H = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  sxd_pkg::cmd_type cmd,
   input  sxd_pkg::req_type req_data,
   output sxd_pkg::rsp_type rsp_data
);

   import sxd_pkg::*;

   localparam int AW   = $clog2(SCREEN_H);
   localparam int TY_W = COORD_W + 1;
   localparam logic [ROW_W-1:0] VISIBLE_MASK = ~{ROW_W{1'b0}} << (ROW_W - SCREEN_W);

   logic               op_ff,       op_in;
   logic [COORD_W-1:0] x_ff,        x_in;
   logic [COORD_W-1:0] y_ff,        y_in;
   logic [OFF_W-1:0]   off_ff,      off_in;
   logic [SPR_W-1:0]   spr_ff,      spr_in;
   logic               in_range_ff, in_range_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      wr_addr_ff,  wr_addr_in;
   logic               hit_ff,      hit_in;
   logic [SCREEN_H-1:0] valid_ff,   valid_in;
   rsp_type            rsp_ff,      rsp_in;

   logic [TY_W-1:0]  ty;
   logic             ty_in_range;
   logic [AW-1:0]    rd_addr;
   logic [ROW_W-1:0] ram_q;
   logic [ROW_W-1:0] old_row;
   logic [ROW_W-1:0] mask;
   logic [ROW_W-1:0] new_row;
   logic [ROW_W-1:0] row_out;
   logic             hit_next;
   logic             do_write;

   // target row of a draw, can run past the bottom edge
   assign ty          = {1'b0, y_ff} + {{(TY_W - OFF_W){1'b0}}, off_ff};
   assign ty_in_range = ty < TY_W'(SCREEN_H);
   assign rd_addr     = (op_ff == OP_READ) ? y_ff[AW-1:0] : ty[AW-1:0];

   // sprite placed at column x, bit 63 is column 0
   assign mask    = (({{(ROW_W - SPR_W){1'b0}}, spr_ff} << (ROW_W - SPR_W)) >> x_ff)
                    & VISIBLE_MASK;
   assign old_row = rd_valid_ff ? ram_q : '0;
   assign new_row = old_row ^ mask;
   assign do_write = cmd.commit && (op_ff == OP_DRAW) && in_range_ff;

   always_comb begin
      if (op_ff == OP_READ) begin
         hit_next = hit_ff;
         row_out  = old_row;
      end else begin
         hit_next = ((off_ff == '0) ? 1'b0 : hit_ff) | (in_range_ff & (|(old_row & mask)));
         row_out  = in_range_ff ? new_row : '0;
      end
   end

   always_comb begin
      op_in       = op_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      off_in      = off_ff;
      spr_in      = spr_ff;
      in_range_in = in_range_ff;
      rd_valid_in = rd_valid_ff;
      wr_addr_in  = wr_addr_ff;
      hit_in      = hit_ff;
      valid_in    = valid_ff;
      rsp_in      = rsp_ff;
      if (cmd.capture) begin
         op_in  = req_data.operation;
         x_in   = mod_small(req_data.x_pos, 7'(SCREEN_W));
         y_in   = mod_small(req_data.y_pos, 7'(SCREEN_H));
         off_in = req_data.row_offset;
         spr_in = req_data.sprite_byte;
      end
      if (cmd.fetch) begin
         in_range_in = ty_in_range;
         rd_valid_in = valid_ff[rd_addr];
         wr_addr_in  = rd_addr;
      end
      if (cmd.commit) begin
         hit_in           = hit_next;
         rsp_in.collision = hit_next;
         rsp_in.row_bits  = row_out;
      end
      if (do_write) begin
         valid_in[wr_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         hit_ff   <= hit_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      off_ff      <= off_in;
      spr_ff      <= spr_in;
      in_range_ff <= in_range_in;
      rd_valid_ff <= rd_valid_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_ff      <= rsp_in;
   end

   sxd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SCREEN_H)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_addr_ff),
      .wr_data (new_row),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_data = rsp_ff;

endmodule

// File: design/sprite_xor_draw_framebuffer.sv
// sprite xor-draw framebuffer: a SCREEN_W x SCREEN_H one-bit screen held as one 64-bit
// word per row, bit 63 leftmost. a draw transaction xors an 8-pixel sprite row in at
// column x mod SCREEN_W, row (y mod SCREEN_H) + row_offset, clipping at the right and
// bottom edges, and returns the updated row and the collision flag (cleared when
// row_offset is zero, set when a lit pixel goes dark). a read transaction returns row
// y mod SCREEN_H and the current flag. every transaction gives exactly one response.
// one transaction goes through capture and coordinate reduction in the accepting cycle,
// then the framebuffer ram read, then update and write-back into the output register;
// the update waits while the output register still holds an unaccepted response.
// a new request is taken in the cycle after the previous response is loaded, so the
// block takes no new transaction before the last one is through, as capture and the
// registered read of the row ram come first. a response left waiting on rsp_ready holds
// the block only when the next result is ready to be loaded. the screen is blank right
// after reset: each row has a valid bit, so there is no clearing pass.
module sprite_xor_draw_framebuffer #(
   parameter int SCREEN_W = 64,
   parameter int SCREEN_H = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sxd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sxd_pkg::rsp_type rsp_data
);

   import sxd_pkg::*;

   // command bundle: capture, ram read, commit
   cmd_type cmd;

   // sequencing and output handshake
   sxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // coordinates, row ram, xor and collision, response register
   sxd_datapath #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: design/sxd_checker.sv
module sxd_checker #(
   parameter int SCREEN_W = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sxd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sxd_pkg::rsp_type rsp_data
);

   import sxd_pkg::*;

   localparam logic [ROW_W-1:0] HIDDEN_MASK = ~(~{ROW_W{1'b0}} << (ROW_W - SCREEN_W));

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // the block is busy in its fetch and execute states after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while busy");

   // columns beyond the screen width never light up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.row_bits & HIDDEN_MASK) == '0)
      else $error("pixel set outside screen width");

endmodule

bind sprite_xor_draw_framebuffer sxd_checker #(
   .SCREEN_W (SCREEN_W)
) u_sxd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
